[design/ncfr_pkg.sv]
// Package: shared types, constants and the CRC-8 byte fold for the frame receiver.
`timescale 1ns / 1ps
package ncfr_pkg;

    localparam int DEFAULT_FRAME_CAPACITY = 64;
    localparam logic [7:0] BEGIN_CODE_RESET = 8'h02;
    localparam logic [7:0] END_CODE_RESET = 8'h03;
    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    typedef enum logic [0:0] {
        CFG_BEGIN_CODE = 1'b0,
        CFG_END_CODE   = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_BADCHAR  = 3'd2,
        KIND_BADCRC   = 3'd3,
        KIND_OVERFLOW = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [6:0]  frame_length;
        logic [7:0]  computed_crc;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  rx_byte;
    } stage_t;

    function automatic logic [7:0] crc8_fold(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] d;
        logic       mix;
        crc = crc_in;
        d = data;
        for (int i = 0; i < 8; i++)
        begin
            mix = crc[0] ^ d[0];
            crc = {1'b0, crc[7:1]};
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return crc;
    endfunction

endpackage

[design/ncfr_in_if.sv]
// Interface: input channel carrying one raw line byte per word.
`timescale 1ns / 1ps
interface ncfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

[design/ncfr_out_if.sv]
// Interface: output channel carrying one decoded result per word.
`timescale 1ns / 1ps
interface ncfr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic [6:0] frame_length;
    logic [7:0] computed_crc;

    modport source (output valid, output kind, output value, output frame_length,
                    output computed_crc, input ready);
    modport sink (input valid, input kind, input value, input frame_length,
                  input computed_crc, output ready);
endinterface

[design/ncfr_in_stage.sv]
// Input register: captures one line byte and holds it until the decoder advances.
`timescale 1ns / 1ps
module ncfr_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    ncfr_in_if.sink         in_ch,
    input  logic            drain,
    output ncfr_pkg::stage_t stage
);
    import ncfr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign in_ch.ready = !valid_reg || drain;
    assign load = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_ch.rx_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.rx_byte = byte_reg;
endmodule

[design/ncfr_core.sv]
// Frame decoder: framing state, nibble check, byte count and running CRC.
`timescale 1ns / 1ps
module ncfr_core #(
    parameter int FRAME_CAPACITY = ncfr_pkg::DEFAULT_FRAME_CAPACITY
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ncfr_pkg::stage_t stage,
    input  logic             advance,
    input  logic [7:0]       begin_code,
    input  logic [7:0]       end_code,
    output logic             res_valid,
    output ncfr_pkg::result_t res
);
    import ncfr_pkg::*;

    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(FRAME_CAPACITY);

    logic             in_frame_reg, in_frame_next;
    logic             end_seen_reg, end_seen_next;
    logic             expect_high_reg, expect_high_next;
    logic [3:0]       high_nibble_reg, high_nibble_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       crc_reg, crc_next;

    logic [7:0] b;
    logic [3:0] nib;
    logic [7:0] full;

    assign b = stage.rx_byte;
    assign nib = b[7:4];
    assign full = {high_nibble_reg, nib};

    always_comb
    begin
        in_frame_next = in_frame_reg;
        end_seen_next = end_seen_reg;
        expect_high_next = expect_high_reg;
        high_nibble_next = high_nibble_reg;
        count_next = count_reg;
        crc_next = crc_reg;
        res_valid = 1'b0;
        res.kind = KIND_DATA;
        res.value = b;
        res.frame_length = 7'(count_reg);
        res.computed_crc = crc_reg;
        priority if (b == 8'd0)
        begin
        end
        else if (b == begin_code)
        begin
            in_frame_next = 1'b1;
            end_seen_next = 1'b0;
            expect_high_next = 1'b1;
            count_next = '0;
            crc_next = '0;
        end
        else if (b == end_code)
        begin
            end_seen_next = 1'b1;
        end
        else if (!in_frame_reg)
        begin
        end
        else if (nib != (b[3:0] ^ NIBBLE_MASK))
        begin
            res_valid = 1'b1;
            res.kind = KIND_BADCHAR;
            in_frame_next = 1'b0;
            end_seen_next = 1'b0;
            count_next = '0;
            crc_next = '0;
        end
        else if (expect_high_reg)
        begin
            high_nibble_next = nib;
            expect_high_next = 1'b0;
        end
        else
        begin
            expect_high_next = 1'b1;
            res_valid = 1'b1;
            res.value = full;
            if (end_seen_reg)
            begin
                res.kind = (full == crc_reg) ? KIND_GOOD : KIND_BADCRC;
                in_frame_next = 1'b0;
                end_seen_next = 1'b0;
                count_next = '0;
                crc_next = '0;
            end
            else if (count_reg < CAPACITY)
            begin
                count_next = count_reg + CNT_W'(1);
                crc_next = crc8_fold(crc_reg, full);
                res.kind = KIND_DATA;
                res.frame_length = 7'(count_next);
                res.computed_crc = crc_next;
            end
            else
            begin
                res.kind = KIND_OVERFLOW;
                in_frame_next = 1'b0;
                end_seen_next = 1'b0;
                count_next = '0;
                crc_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            end_seen_reg <= 1'b0;
            expect_high_reg <= 1'b0;
            high_nibble_reg <= '0;
            count_reg <= '0;
            crc_reg <= '0;
        end
        else if (advance)
        begin
            in_frame_reg <= in_frame_next;
            end_seen_reg <= end_seen_next;
            expect_high_reg <= expect_high_next;
            high_nibble_reg <= high_nibble_next;
            count_reg <= count_next;
            crc_reg <= crc_next;
        end
    end
endmodule

[design/ncfr_out_stage.sv]
// Result register: holds one result word until the sink takes it.
`timescale 1ns / 1ps
module ncfr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              res_valid,
    input  ncfr_pkg::result_t res,
    output logic              can_take,
    ncfr_out_if.source        out_ch
);
    import ncfr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_take = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = res_valid;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.kind = res_reg.kind;
    assign out_ch.value = res_reg.value;
    assign out_ch.frame_length = res_reg.frame_length;
    assign out_ch.computed_crc = res_reg.computed_crc;
endmodule

[design/nibble_complement_frame_receiver.sv]
// Top level: nibble-complement frame receiver with CRC-8 check.
//
//   channel   direction  word
//   in_ch     in         rx_byte
//   out_ch    out        kind, value, frame_length, computed_crc
//   cfg_*     in         index 0 begin_code, index 1 end_code
//
// One byte per cycle sustained while the output is not stalled; a byte passes from input
// to result register (input register, then decode and CRC fold into the result register).
// Reset clears framing state, count and CRC and loads codes 0x02 and 0x03.
// A stalled output holds the result; the input register keeps one byte meanwhile.
`timescale 1ns / 1ps
module nibble_complement_frame_receiver #(
    parameter int FRAME_CAPACITY = ncfr_pkg::DEFAULT_FRAME_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    ncfr_in_if.sink     in_ch,
    ncfr_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import ncfr_pkg::*;

    logic [7:0] begin_code_reg;
    logic [7:0] end_code_reg;
    stage_t     stage;
    logic       can_take;
    logic       advance;
    logic       res_valid;
    result_t    res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_code_reg <= BEGIN_CODE_RESET;
            end_code_reg <= END_CODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BEGIN_CODE: begin_code_reg <= cfg_data;
                CFG_END_CODE:   end_code_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign advance = stage.valid && can_take;

    ncfr_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .drain (can_take),
        .stage (stage)
    );

    ncfr_core #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .advance    (advance),
        .begin_code (begin_code_reg),
        .end_code   (end_code_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    ncfr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .can_take  (can_take),
        .out_ch    (out_ch)
    );
endmodule

[tb/nibble_complement_frame_receiver_tb.sv]
// Testbench: drives line bytes and code writes into the frame receiver and checks every result word.
`timescale 1ns / 1ps
module nibble_complement_frame_receiver_tb;
    import ncfr_pkg::*;

    localparam int FRAME_CAP = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [6:0] length;
        logic [7:0] crc;
    } frame_event_t;

    typedef struct {
        logic [7:0]   rx;
        bit           typed;
        bit           emits;
        frame_event_t ev;
    } line_row_t;

    typedef struct {
        logic [7:0] begin_code;
        logic [7:0] end_code;
        int         words;
        int         send_pct;
        int         recv_pct;
    } code_phase_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    ncfr_in_if in_ch ();
    ncfr_out_if out_ch ();

    nibble_complement_frame_receiver #(
        .FRAME_CAPACITY(FRAME_CAP)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [7:0] code_begin;
    logic [7:0] code_end;
    bit         frame_open;
    bit         crc_armed;
    bit         want_high;
    logic [3:0] held_nibble;
    int         accepted_len;
    logic [7:0] frame_crc;

    frame_event_t pending_events[$];
    int unsigned  mismatch_count;
    int unsigned  line_words;
    int           send_pct;
    int           recv_pct;
    bit           hold_request;

    line_row_t directed_rows [20] = '{
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'h03, 1'b1, 1'b0, '0},
        '{8'h02, 1'b1, 1'b0, '0},
        '{8'h55, 1'b1, 1'b1, '{KIND_BADCHAR, 8'h55, 7'd0, 8'h00}},
        '{8'h02, 1'b1, 1'b0, '0},
        '{8'h0F, 1'b1, 1'b0, '0},
        '{8'h0F, 1'b1, 1'b1, '{KIND_DATA, 8'h00, 7'd1, 8'h00}},
        '{8'hF0, 1'b0, 1'b0, '0},
        '{8'hF0, 1'b0, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'h03, 1'b0, 1'b0, '0},
        '{8'h0F, 1'b0, 1'b0, '0},
        '{8'h0F, 1'b1, 1'b1, '{KIND_GOOD, 8'h00, 7'd0, 8'h00}},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'h1E, 1'b0, 1'b0, '0},
        '{8'hE1, 1'b0, 1'b0, '0},
        '{8'h03, 1'b0, 1'b0, '0},
        '{8'hF0, 1'b0, 1'b0, '0},
        '{8'hF0, 1'b0, 1'b0, '0}
    };

    code_phase_t code_phases [6] = '{
        '{8'h02, 8'h03, 320, 31, 58},
        '{8'hFF, 8'h00, 320, 31, 58},
        '{8'h00, 8'hFF, 80, 58, 31},
        '{8'h5A, 8'h5A, 320, 58, 31},
        '{8'h0F, 8'hF0, 320, 0, 0},
        '{8'hA5, 8'h7E, 320, 0, 0}
    };

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        acc = crc ^ data;
        repeat (8)
        begin
            acc = acc[0] ? ((acc >> 1) ^ 8'h8C) : (acc >> 1);
        end
        return acc;
    endfunction

    function automatic frame_event_t frame_event(input kind_t kind, input logic [7:0] value);
        frame_event_t ev;
        ev.kind = kind;
        ev.value = value;
        ev.length = accepted_len[6:0];
        ev.crc = frame_crc;
        return ev;
    endfunction

    function automatic void close_frame();
        frame_open = 1'b0;
        crc_armed = 1'b0;
        accepted_len = 0;
        frame_crc = 8'h00;
    endfunction

    function automatic bit decode_line_byte(input logic [7:0] b, output frame_event_t ev);
        logic [3:0] nib;
        logic [7:0] full;
        ev = '0;
        if (b == 8'h00)
        begin
            return 1'b0;
        end
        if (b == code_begin)
        begin
            frame_open = 1'b1;
            crc_armed = 1'b0;
            want_high = 1'b1;
            accepted_len = 0;
            frame_crc = 8'h00;
            return 1'b0;
        end
        if (b == code_end)
        begin
            crc_armed = 1'b1;
            return 1'b0;
        end
        if (!frame_open)
        begin
            return 1'b0;
        end
        nib = b[7:4];
        if (nib != ~b[3:0])
        begin
            ev = frame_event(KIND_BADCHAR, b);
            close_frame();
            return 1'b1;
        end
        if (want_high)
        begin
            held_nibble = nib;
            want_high = 1'b0;
            return 1'b0;
        end
        full = {held_nibble, nib};
        want_high = 1'b1;
        if (crc_armed)
        begin
            ev = frame_event((full == frame_crc) ? KIND_GOOD : KIND_BADCRC, full);
            close_frame();
            return 1'b1;
        end
        if (accepted_len < FRAME_CAP)
        begin
            accepted_len++;
            frame_crc = crc8_update(frame_crc, full);
            ev = frame_event(KIND_DATA, full);
            return 1'b1;
        end
        ev = frame_event(KIND_OVERFLOW, full);
        close_frame();
        return 1'b1;
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input bit typed_emits = 1'b0, input frame_event_t typed_ev = '0);
        frame_event_t ev;
        bit emits;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        emits = decode_line_byte(b, ev);
        if (typed)
        begin
            emits = typed_emits;
            ev = typed_ev;
        end
        if (emits)
        begin
            pending_events.push_back(ev);
        end
        if (b != 8'h00)
        begin
            line_words++;
        end
    endtask

    task automatic send_noisy(input logic [7:0] b);
        int r;
        r = $urandom_range(0, 199);
        if (r < 5)
        begin
            send_byte(8'h00);
        end
        send_byte((r >= 5 && r < 8) ? 8'($urandom) : b);
    endtask

    task automatic send_data(input logic [7:0] d);
        send_noisy({d[7:4], ~d[7:4]});
        send_noisy({d[3:0], ~d[3:0]});
    endtask

    task automatic send_frame();
        int r;
        int n;
        logic [7:0] d;
        logic [7:0] crc;
        r = $urandom_range(0, 99);
        n = (r < 85) ? $urandom_range(0, 8) : (r < 93) ? $urandom_range(9, 40)
                                                       : $urandom_range(60, 70);
        crc = 8'h00;
        send_noisy(code_begin);
        for (int i = 0; i < n; i++)
        begin
            d = 8'($urandom);
            crc = crc8_update(crc, d);
            send_data(d);
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            send_noisy(code_end);
            send_data(crc);
        end
        else if (r < 85)
        begin
            send_noisy(code_end);
            send_data(8'($urandom));
        end
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_events.size() != 0)
        begin
            note_failure($sformatf("%0d expected words never arrived", pending_events.size()));
            pending_events.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_codes(input logic [7:0] begin_val, input logic [7:0] end_val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BEGIN_CODE;
        cfg_data <= begin_val;
        @(negedge clk);
        cfg_index <= CFG_END_CODE;
        cfg_data <= end_val;
        @(negedge clk);
        cfg_we <= 1'b0;
        code_begin = begin_val;
        code_end = end_val;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                out_ch.ready <= !($urandom_range(0, 99) < recv_pct);
            end
        end
    end

    initial
    begin : result_check
        frame_event_t got;
        frame_event_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.kind, out_ch.value, out_ch.frame_length, out_ch.computed_crc};
                if (pending_events.size() == 0)
                begin
                    note_failure($sformatf("unexpected word kind=%0d value=%02h len=%0d crc=%02h",
                                           got.kind, got.value, got.length, got.crc));
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (got !== want)
                    begin
                        note_failure($sformatf({"mismatch: expected kind=%0d value=%02h len=%0d ",
                                                "crc=%02h, got kind=%0d value=%02h len=%0d crc=%02h"},
                                               want.kind, want.value, want.length, want.crc,
                                               got.kind, got.value, got.length, got.crc));
                    end
                end
            end
        end
    end

    initial
    begin
        int target;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BEGIN_CODE;
        cfg_data = 8'h00;
        in_ch.valid = 1'b0;
        in_ch.rx_byte = 8'h00;
        hold_request = 1'b0;
        mismatch_count = 0;
        line_words = 0;
        send_pct = code_phases[0].send_pct;
        recv_pct = code_phases[0].recv_pct;
        code_begin = BEGIN_CODE_RESET;
        code_end = END_CODE_RESET;
        frame_open = 1'b0;
        crc_armed = 1'b0;
        want_high = 1'b0;
        held_nibble = 4'h0;
        accepted_len = 0;
        frame_crc = 8'h00;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].emits,
                      directed_rows[i].ev);
        end
        drain_results();

        foreach (code_phases[p])
        begin
            send_pct = code_phases[p].send_pct;
            recv_pct = code_phases[p].recv_pct;
            write_codes(code_phases[p].begin_code, code_phases[p].end_code);
            if (p == 4)
            begin
                hold_request = 1'b1;
            end
            target = line_words + code_phases[p].words;
            while (line_words < target)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    send_frame();
                end
                else
                begin
                    send_byte(8'($urandom));
                end
            end
            drain_results();
        end

        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
design/ncfr_pkg.sv
design/ncfr_in_if.sv
design/ncfr_out_if.sv
design/ncfr_in_stage.sv
design/ncfr_core.sv
design/ncfr_out_stage.sv
design/nibble_complement_frame_receiver.sv
tb/nibble_complement_frame_receiver_tb.sv
